// ===== hw/rtl/pcb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the passive cell balancer.
package pcb_pkg;

  localparam int NUM_CELLS  = 6;
  localparam int CELL_W     = 13;
  localparam int PACK_W     = 16;
  localparam int CHG_W      = 6;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CELL_W-1:0] MIN_START_MV = CELL_W'(4300);
  localparam logic [CELL_W-1:0] HYST_MV      = CELL_W'(2);
  localparam logic [CELL_W-1:0] RESET_RELEASE_MV = CELL_W'(4200);
  localparam logic [CNT_W-1:0]  RESET_CELL_COUNT = CNT_W'(6);

  // Charge per tick is (v / 22 ohm) * 100 ms / 1000, which floors to v / 220.
  // Divide by 220 with a reciprocal: exact for every 13-bit voltage.
  localparam int RECIP_W     = 14;
  localparam int RECIP_SHIFT = 21;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(9533);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MV = CFG_IDX_W'(1);

  typedef logic [CELL_W-1:0] cell_mv_t;
  typedef logic [CHG_W-1:0]  charge_t;

  // Load enables of the two pipeline stages shared by lanes and merge.
  typedef struct packed {
    logic ld1;
    logic ld2;
  } pcb_stage_en_t;

endpackage

// ===== hw/rtl/pcb_lane.sv =====
`timescale 1ns / 1ps
// One cell lane: register the voltage, compute its charge and bleed request.
module pcb_lane (
  input  logic                   clk,
  input  pcb_pkg::pcb_stage_en_t ctl,
  input  logic                   used_i,
  input  pcb_pkg::cell_mv_t      cell_mv_i,
  input  pcb_pkg::cell_mv_t      lo_i,
  output pcb_pkg::cell_mv_t      lo_cand_o,
  output pcb_pkg::cell_mv_t      hi_cand_o,
  output logic                   bleed_req_o,
  output pcb_pkg::charge_t       charge_o
);
  import pcb_pkg::*;

  logic [CELL_W+RECIP_W-1:0] prod;
  cell_mv_t v1_r, v2_r;
  logic     used1_r;
  charge_t  q1_r, q2_r;

  assign prod = (CELL_W+RECIP_W)'(cell_mv_i) * (CELL_W+RECIP_W)'(RECIP_M);

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      v1_r    <= cell_mv_i;
      used1_r <= used_i;
      q1_r    <= prod[RECIP_SHIFT +: CHG_W];
    end
    if (ctl.ld2) begin
      v2_r <= v1_r;
      q2_r <= q1_r;
    end
  end

  // Unused cells drop out of min, max and sum.
  assign lo_cand_o = used1_r ? v1_r : MIN_START_MV;
  assign hi_cand_o = used1_r ? v1_r : '0;

  assign bleed_req_o = {1'b0, v2_r} > ({1'b0, lo_i} + {1'b0, HYST_MV});
  assign charge_o    = q2_r;

endmodule

// ===== hw/rtl/pcb_merge.sv =====
`timescale 1ns / 1ps
// Merge stage: minimum, maximum and sum over the lane candidates.
module pcb_merge (
  input  logic                   clk,
  input  pcb_pkg::pcb_stage_en_t ctl,
  input  pcb_pkg::cell_mv_t      lo_cand_i [pcb_pkg::NUM_CELLS],
  input  pcb_pkg::cell_mv_t      hi_cand_i [pcb_pkg::NUM_CELLS],
  output pcb_pkg::cell_mv_t      lo_o,
  output pcb_pkg::cell_mv_t      hi_o,
  output logic [pcb_pkg::PACK_W-1:0] sum_o
);
  import pcb_pkg::*;

  cell_mv_t          lo_nxt, hi_nxt, lo_r, hi_r;
  logic [PACK_W-1:0] sum_nxt, sum_r;

  always_comb begin
    lo_nxt  = MIN_START_MV;
    hi_nxt  = '0;
    sum_nxt = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (lo_cand_i[i] < lo_nxt) lo_nxt = lo_cand_i[i];
      if (hi_cand_i[i] > hi_nxt) hi_nxt = hi_cand_i[i];
      sum_nxt = sum_nxt + PACK_W'(hi_cand_i[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign lo_o  = lo_r;
  assign hi_o  = hi_r;
  assign sum_o = sum_r;

endmodule

// ===== hw/rtl/passive_cell_balancer_top.sv =====
`timescale 1ns / 1ps
// Passive cell balancer top level: lanes, merge, duty-cycle decision, output.
//
// Each item carries six cell voltages and a charging flag and yields one
// result item. The block is a three-stage pipeline: six lanes register the
// cells and compute per-cell charge, a merge stage forms lowest, highest and
// pack sum, and the last stage takes the bleed decision, updates the duty
// phase, finish counter and bleed bits, and holds the result in the output
// register. It accepts one item per cycle while in_stall is low; an item
// passes the lane, merge and output registers in order, and each stage holds
// while the one after it is full and stalled, so in_stall rises only when all
// three stages are full. The duty state advances once per item, in item order,
// so results match a strictly sequential evaluation. Configuration writes are
// always ready and must only be made while no item is in flight.
module passive_cell_balancer_top #(
  parameter int FINISH_RELOAD = 10,
  parameter int PHASE_LAST    = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pcb_pkg::CELL_W-1:0]      in_cell0_mv,
  input  logic [pcb_pkg::CELL_W-1:0]      in_cell1_mv,
  input  logic [pcb_pkg::CELL_W-1:0]      in_cell2_mv,
  input  logic [pcb_pkg::CELL_W-1:0]      in_cell3_mv,
  input  logic [pcb_pkg::CELL_W-1:0]      in_cell4_mv,
  input  logic [pcb_pkg::CELL_W-1:0]      in_cell5_mv,
  input  logic                            in_charging,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pcb_pkg::NUM_CELLS-1:0]   out_bleed_mask,
  output logic                            out_finished,
  output logic [pcb_pkg::PACK_W-1:0]      out_pack_mv,
  output logic [pcb_pkg::CELL_W-1:0]      out_lowest_mv,
  output logic [pcb_pkg::CELL_W-1:0]      out_highest_mv,
  output logic [pcb_pkg::CHG_W-1:0]       out_charge0_mas,
  output logic [pcb_pkg::CHG_W-1:0]       out_charge1_mas,
  output logic [pcb_pkg::CHG_W-1:0]       out_charge2_mas,
  output logic [pcb_pkg::CHG_W-1:0]       out_charge3_mas,
  output logic [pcb_pkg::CHG_W-1:0]       out_charge4_mas,
  output logic [pcb_pkg::CHG_W-1:0]       out_charge5_mas,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pcb_pkg::*;

  localparam int PHASE_W = (PHASE_LAST > 1) ? $clog2(PHASE_LAST + 1) : 1;
  localparam int FIN_W   = (FINISH_RELOAD > 1) ? $clog2(FINISH_RELOAD + 1) : 1;

  // Configuration registers
  logic [CNT_W-1:0] cell_count_r;
  cell_mv_t         release_mv_r;

  // Pipeline control
  logic          v1_r, v2_r, out_valid_r;
  logic          adv1, adv2, adv3;
  pcb_stage_en_t ctl;
  logic          chg1_r, chg2_r;

  // Duty state
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [FIN_W-1:0]     finish_r, finish_nxt;
  logic [NUM_CELLS-1:0] bleed_r, bleed_nxt, bleed_set;
  logic                 decide;

  // Lane wiring
  cell_mv_t             cell_mv [NUM_CELLS];
  cell_mv_t             lo_cand [NUM_CELLS];
  cell_mv_t             hi_cand [NUM_CELLS];
  charge_t              lane_charge [NUM_CELLS];
  logic [NUM_CELLS-1:0] used;
  logic [NUM_CELLS-1:0] req;
  cell_mv_t             lo_mv, hi_mv;
  logic [PACK_W-1:0]    sum_mv;

  // Output registers
  logic [NUM_CELLS-1:0] mask_r;
  logic                 finished_r;
  logic [PACK_W-1:0]    pack_r;
  cell_mv_t             lowest_r, highest_r;
  charge_t              charge_r [NUM_CELLS];

  // Configuration: always ready, unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= RESET_CELL_COUNT;
      release_mv_r <= RESET_RELEASE_MV;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CELL_COUNT: cell_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_RELEASE_MV: release_mv_r <= cfg_wdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: a stage loads when empty or when its successor moves.
  assign adv3     = !out_valid_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign ctl.ld1  = in_valid && adv1;
  assign ctl.ld2  = v1_r && adv2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) chg1_r <= in_charging;
    if (ctl.ld2) chg2_r <= chg1_r;
  end

  assign cell_mv[0] = in_cell0_mv;
  assign cell_mv[1] = in_cell1_mv;
  assign cell_mv[2] = in_cell2_mv;
  assign cell_mv[3] = in_cell3_mv;
  assign cell_mv[4] = in_cell4_mv;
  assign cell_mv[5] = in_cell5_mv;

  // A cell takes part in min, max and sum when its index is below the count;
  // counts above the cell number saturate by themselves.
  always_comb begin
    for (int i = 0; i < NUM_CELLS; i++) begin
      used[i] = CNT_W'(i) < cell_count_r;
    end
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_lane
    pcb_lane u_lane (
      .clk         (clk),
      .ctl         (ctl),
      .used_i      (used[g]),
      .cell_mv_i   (cell_mv[g]),
      .lo_i        (lo_mv),
      .lo_cand_o   (lo_cand[g]),
      .hi_cand_o   (hi_cand[g]),
      .bleed_req_o (req[g]),
      .charge_o    (lane_charge[g])
    );
  end

  pcb_merge u_merge (
    .clk       (clk),
    .ctl       (ctl),
    .lo_cand_i (lo_cand),
    .hi_cand_i (hi_cand),
    .lo_o      (lo_mv),
    .hi_o      (hi_mv),
    .sum_o     (sum_mv)
  );

  // Decision: only in phase 0, while charging, with the top cell above release.
  always_comb begin
    decide     = (phase_r == PHASE_W'(0)) && chg2_r && (hi_mv > release_mv_r);
    bleed_set  = decide ? req : bleed_r;
    finish_nxt = finish_r;
    if (decide) begin
      if (|req) begin
        finish_nxt = FIN_W'(FINISH_RELOAD);
      end else if (finish_r != '0) begin
        finish_nxt = finish_r - 1'b1;
      end
    end
    // Wrap the duty phase and drop every bleed bit at the end of the cycle.
    if (phase_r == PHASE_W'(PHASE_LAST)) begin
      phase_nxt = '0;
      bleed_nxt = '0;
    end else begin
      phase_nxt = phase_r + 1'b1;
      bleed_nxt = bleed_set;
    end
  end

  // Advance the duty state once per item as it enters the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      finish_r <= FIN_W'(FINISH_RELOAD);
      bleed_r  <= '0;
    end else if (v2_r && adv3) begin
      phase_r  <= phase_nxt;
      finish_r <= finish_nxt;
      bleed_r  <= bleed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && adv3) begin
      mask_r     <= bleed_nxt;
      finished_r <= (finish_nxt == '0);
      pack_r     <= sum_mv;
      lowest_r   <= lo_mv;
      highest_r  <= hi_mv;
      for (int i = 0; i < NUM_CELLS; i++) begin
        charge_r[i] <= (decide && req[i]) ? lane_charge[i] : '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bleed_mask  = mask_r;
  assign out_finished    = finished_r;
  assign out_pack_mv     = pack_r;
  assign out_lowest_mv   = lowest_r;
  assign out_highest_mv  = highest_r;
  assign out_charge0_mas = charge_r[0];
  assign out_charge1_mas = charge_r[1];
  assign out_charge2_mas = charge_r[2];
  assign out_charge3_mas = charge_r[3];
  assign out_charge4_mas = charge_r[4];
  assign out_charge5_mas = charge_r[5];

  // Bleed bits are always clear at the start of a duty cycle.
  a_phase0_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PHASE_W'(0)) |-> (bleed_r == '0))
    else $error("bleed bits set in duty phase 0");

  // A cell reporting charge must have its bleed bit in the same result.
  a_charge_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((|charge_r[0] && !mask_r[0]) || (|charge_r[1] && !mask_r[1]) ||
       (|charge_r[2] && !mask_r[2]) || (|charge_r[3] && !mask_r[3]) ||
       (|charge_r[4] && !mask_r[4]) || (|charge_r[5] && !mask_r[5])) == 1'b0)
    else $error("charge reported for a cell that does not bleed");

  // The input only stalls with every pipeline stage full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && out_valid_r))
    else $error("input stalled with an empty stage");

  // The finished flag tracks the finish counter of the last result.
  a_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (finished_r == (finish_r == '0)))
    else $error("finished flag disagrees with finish counter");

endmodule

// ===== test/passive_cell_balancer_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the passive cell balancer: predicted ticks against DUT results.

// One input tick and one result tick as the scoreboard sees them.
typedef struct {
  pcb_pkg::cell_mv_t volt [pcb_pkg::NUM_CELLS];
  logic              charging;
} tick_in_t;

typedef struct {
  logic [pcb_pkg::NUM_CELLS-1:0] mask;
  logic                          finished;
  logic [pcb_pkg::PACK_W-1:0]    pack;
  pcb_pkg::cell_mv_t             lowest;
  pcb_pkg::cell_mv_t             highest;
  pcb_pkg::charge_t              charge [pcb_pkg::NUM_CELLS];
} tick_out_t;

// Result scoreboard: runs its own copy of the balancing state and holds expected ticks.
class balance_scoreboard;
  localparam int CELLS         = pcb_pkg::NUM_CELLS;
  localparam int LOW_START_MV  = 4300;
  localparam int HYST_MV       = 2;
  localparam int BLEED_OHMS    = 22;
  localparam int TICK_MS       = 100;
  localparam int MS_PER_S      = 1000;
  localparam int FINISH_RELOAD = 10;
  localparam int PHASE_LAST    = 2;
  localparam int MAX_REPORTS   = 50;

  // register copies
  int unsigned cell_count = 6;
  int unsigned release_mv = 4200;
  // balancing state
  int unsigned duty_phase   = 0;
  int unsigned finish_count = FINISH_RELOAD;
  logic [CELLS-1:0] bleed_bits = '0;

  tick_out_t expected_ticks [$];
  int errors;
  int items_seen;
  int results_checked;
  int bleed_ticks;
  int finished_ticks;

  function void write_reg(logic [pcb_pkg::CFG_IDX_W-1:0] idx,
                          logic [pcb_pkg::CFG_DATA_W-1:0] data);
    // spare indexes fall through: the write has no effect
    if (idx == pcb_pkg::CFG_CELL_COUNT)
      cell_count = 32'(data & 13'h7);
    else if (idx == pcb_pkg::CFG_RELEASE_MV)
      release_mv = 32'(data);
  endfunction

  function int pending();
    return expected_ticks.size();
  endfunction

  // Advance the balancing state by one accepted tick and queue its result.
  function void note_item(tick_in_t t);
    tick_out_t   r;
    int unsigned used;
    int unsigned lo;
    int unsigned hi;
    int unsigned sum;
    int unsigned v;
    bit          bled;
    int          i;
    used = (cell_count > CELLS) ? CELLS : cell_count;
    lo   = LOW_START_MV;
    hi   = 0;
    sum  = 0;
    bled = 1'b0;
    for (i = 0; i < CELLS; i++)
      r.charge[i] = '0;
    for (i = 0; i < used; i++) begin
      v = 32'(t.volt[i]);
      if (v < lo) lo = v;
      if (v > hi) hi = v;
      sum = (sum + v) & 32'hFFFF;
    end
    // duty-cycle decision only at phase zero
    if (duty_phase == 0 && t.charging && hi > release_mv) begin
      for (i = 0; i < CELLS; i++) begin
        v = 32'(t.volt[i]);
        if (v > lo + HYST_MV) begin
          bleed_bits[i] = 1'b1;
          r.charge[i]   = pcb_pkg::CHG_W'(((v / BLEED_OHMS) * TICK_MS) / MS_PER_S);
          finish_count  = FINISH_RELOAD;
          bled          = 1'b1;
        end else begin
          bleed_bits[i] = 1'b0;
        end
      end
      if (bleed_bits == '0 && finish_count > 0)
        finish_count--;
    end
    duty_phase++;
    if (duty_phase > PHASE_LAST) begin
      bleed_bits = '0;
      duty_phase = 0;
    end
    r.mask     = bleed_bits;
    r.finished = (finish_count == 0);
    r.pack     = pcb_pkg::PACK_W'(sum);
    r.lowest   = pcb_pkg::CELL_W'(lo);
    r.highest  = pcb_pkg::CELL_W'(hi);
    items_seen++;
    if (bled) bleed_ticks++;
    if (r.finished) finished_ticks++;
    expected_ticks.push_back(r);
  endfunction

  function void compare_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s differs: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  function void check_result(tick_out_t got);
    tick_out_t want;
    int        i;
    if (expected_ticks.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: result with no tick waiting: expected none, actual mask %0d pack %0d",
                 $time, got.mask, got.pack);
      return;
    end
    want = expected_ticks.pop_front();
    results_checked++;
    compare_field("bleed_mask", want.mask, got.mask);
    compare_field("finished", want.finished, got.finished);
    compare_field("pack_mv", want.pack, got.pack);
    compare_field("lowest_mv", want.lowest, got.lowest);
    compare_field("highest_mv", want.highest, got.highest);
    for (i = 0; i < CELLS; i++)
      compare_field($sformatf("charge%0d_mas", i), want.charge[i], got.charge[i]);
  endfunction
endclass

module passive_cell_balancer_top_tb;
  import pcb_pkg::*;

  localparam int FINISH_RELOAD = 10;
  localparam int PHASE_LAST    = 2;
  localparam int IDLE_PCT      = 34;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 150;
  localparam int RUN_ITEMS     = 30;

  // indexes past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  cell_mv_t              in_cell0_mv = '0;
  cell_mv_t              in_cell1_mv = '0;
  cell_mv_t              in_cell2_mv = '0;
  cell_mv_t              in_cell3_mv = '0;
  cell_mv_t              in_cell4_mv = '0;
  cell_mv_t              in_cell5_mv = '0;
  logic                  in_charging = 1'b0;

  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [NUM_CELLS-1:0]  out_bleed_mask;
  logic                  out_finished;
  logic [PACK_W-1:0]     out_pack_mv;
  cell_mv_t              out_lowest_mv;
  cell_mv_t              out_highest_mv;
  charge_t               out_charge0_mas;
  charge_t               out_charge1_mas;
  charge_t               out_charge2_mas;
  charge_t               out_charge3_mas;
  charge_t               out_charge4_mas;
  charge_t               out_charge5_mas;

  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  balance_scoreboard sb = new();

  // Stretch of the run with both sides streaming: no gaps, no stalls.
  bit steady = 1'b0;
  int cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  passive_cell_balancer_top #(
    .FINISH_RELOAD(FINISH_RELOAD),
    .PHASE_LAST   (PHASE_LAST)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cell0_mv    (in_cell0_mv),
    .in_cell1_mv    (in_cell1_mv),
    .in_cell2_mv    (in_cell2_mv),
    .in_cell3_mv    (in_cell3_mv),
    .in_cell4_mv    (in_cell4_mv),
    .in_cell5_mv    (in_cell5_mv),
    .in_charging    (in_charging),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bleed_mask (out_bleed_mask),
    .out_finished   (out_finished),
    .out_pack_mv    (out_pack_mv),
    .out_lowest_mv  (out_lowest_mv),
    .out_highest_mv (out_highest_mv),
    .out_charge0_mas(out_charge0_mas),
    .out_charge1_mas(out_charge1_mas),
    .out_charge2_mas(out_charge2_mas),
    .out_charge3_mas(out_charge3_mas),
    .out_charge4_mas(out_charge4_mas),
    .out_charge5_mas(out_charge5_mas),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // Receiver back-pressure: stall about a third of the cycles outside the steady stretch.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: a correct run finishes far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d ticks outstanding", cycles, sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // Register copies follow every accepted configuration write.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready)
      sb.write_reg(cfg_index, cfg_wdata);
  end

  // Predict each accepted item from the port values seen at the edge.
  always @(posedge clk) begin
    tick_in_t t;
    if (rst_n && in_valid && !in_stall) begin
      t.volt[0]  = in_cell0_mv;
      t.volt[1]  = in_cell1_mv;
      t.volt[2]  = in_cell2_mv;
      t.volt[3]  = in_cell3_mv;
      t.volt[4]  = in_cell4_mv;
      t.volt[5]  = in_cell5_mv;
      t.charging = in_charging;
      sb.note_item(t);
    end
  end

  // Check each accepted result against the oldest expected tick.
  always @(posedge clk) begin
    tick_out_t r;
    if (rst_n && out_valid && !out_stall) begin
      r.mask      = out_bleed_mask;
      r.finished  = out_finished;
      r.pack      = out_pack_mv;
      r.lowest    = out_lowest_mv;
      r.highest   = out_highest_mv;
      r.charge[0] = out_charge0_mas;
      r.charge[1] = out_charge1_mas;
      r.charge[2] = out_charge2_mas;
      r.charge[3] = out_charge3_mas;
      r.charge[4] = out_charge4_mas;
      r.charge[5] = out_charge5_mas;
      sb.check_result(r);
    end
  end

  // Present one item, with random idle cycles ahead of it; return once accepted.
  // Valid stays high on return so back-to-back items need no extra assignment.
  task automatic send_tick(tick_in_t t);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cell0_mv <= t.volt[0];
    in_cell1_mv <= t.volt[1];
    in_cell2_mv <= t.volt[2];
    in_cell3_mv <= t.volt[3];
    in_cell4_mv <= t.volt[4];
    in_cell5_mv <= t.volt[5];
    in_charging <= t.charging;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender until every expected tick has come back, then let the pipe settle.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic tick_in_t tick_of(int c0, int c1, int c2, int c3, int c4, int c5,
                                       bit chg);
    tick_in_t t;
    t.volt[0]  = CELL_W'(c0);
    t.volt[1]  = CELL_W'(c1);
    t.volt[2]  = CELL_W'(c2);
    t.volt[3]  = CELL_W'(c3);
    t.volt[4]  = CELL_W'(c4);
    t.volt[5]  = CELL_W'(c5);
    t.charging = chg;
    return t;
  endfunction

  // Center a run so its top cell nears the release level; random if release is 0 or >= 8000.
  function automatic int run_center(bit tight);
    int rel;
    int c;
    rel = sb.release_mv;
    if (rel == 0 || rel >= 8000)
      c = $urandom_range(4380, 2500);
    else if (tight)
      c = rel + 1 + $urandom_range(20);
    else
      c = rel - 20 + $urandom_range(60);
    if (c < 0) c = 0;
    if (c > 8179) c = 8179;
    return c;
  endfunction

  // Mostly clustered cells with random spread; some full-range and corner noise.
  function automatic tick_in_t random_tick(bit tight, int center);
    tick_in_t t;
    int       roll;
    int       i;
    int       pick;
    roll = $urandom_range(99);
    for (i = 0; i < NUM_CELLS; i++) begin
      if (roll < 10) begin
        t.volt[i] = CELL_W'($urandom_range(8191));
      end else if (roll < 18) begin
        pick = $urandom_range(5);
        case (pick)
          0:       t.volt[i] = CELL_W'(0);
          1:       t.volt[i] = CELL_W'(8191);
          2:       t.volt[i] = CELL_W'(4300);
          3:       t.volt[i] = CELL_W'(4302);
          4:       t.volt[i] = CELL_W'(4303);
          default: t.volt[i] = CELL_W'($urandom_range(8191));
        endcase
      end else if (tight) begin
        t.volt[i] = CELL_W'(center + $urandom_range(2));
      end else begin
        t.volt[i] = CELL_W'(center + $urandom_range(12));
      end
    end
    t.charging = (roll < 18) ? 1'($urandom_range(1)) : ($urandom_range(99) < 85);
    return t;
  endfunction

  initial begin
    tick_in_t              directed [$];
    tick_in_t              t;
    cell_mv_t              phase_release [NUM_PHASES];
    logic [CFG_DATA_W-1:0] phase_count [NUM_PHASES];
    bit                    tight;
    int                    center;
    int                    p;
    int                    k;

    // cell count words carry junk in the upper bits; only the low three count
    phase_count   = '{13'd1, 13'd0, 13'd6, 13'h1FFF, 13'd3, 13'd6, 13'd2, 13'h1FF5};
    phase_release = '{13'd0, 13'd4000, 13'd8191, 13'd3900, 13'd4150, 13'd0, 13'd4280,
                      13'd4230};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks under the reset configuration. The duty phase advances every
    // tick, so the decision ticks are the 1st, 4th, 7th and so on.
    directed.push_back(tick_of(4250, 4250, 4250, 4250, 4250, 4250, 1'b1)); // no spread
    directed.push_back(tick_of(0, 0, 0, 0, 0, 0, 1'b0));
    directed.push_back(tick_of(8191, 8191, 8191, 8191, 8191, 8191, 1'b1));
    // hysteresis edge: lowest + 2 holds, lowest + 3 bleeds
    directed.push_back(tick_of(4200, 4202, 4203, 4250, 4400, 4201, 1'b1));
    directed.push_back(tick_of(8191, 8191, 8191, 8191, 8191, 8191, 1'b1)); // bits held
    directed.push_back(tick_of(4303, 4200, 0, 8191, 4299, 4302, 1'b1));    // bits cleared
    // all above the starting minimum: lowest stays 4300, every cell bleeds
    directed.push_back(tick_of(8191, 8191, 8191, 8191, 8191, 8191, 1'b1));
    directed.push_back(tick_of(13'h1555, 13'h0AAA, 13'h1555, 13'h0AAA, 13'h1555, 13'h0AAA,
                               1'b1));
    directed.push_back(tick_of(13'h0AAA, 13'h1555, 13'h0AAA, 13'h1555, 13'h0AAA, 13'h1555,
                               1'b0));
    // not charging at a decision tick
    directed.push_back(tick_of(4100, 4500, 4600, 4700, 4800, 4900, 1'b0));
    directed.push_back(tick_of(1, 2, 4, 8, 16, 32, 1'b1));
    directed.push_back(tick_of(64, 128, 256, 512, 1024, 2048, 1'b1));
    // highest equal to the release level: no decision
    directed.push_back(tick_of(4100, 4150, 4200, 4180, 4120, 4200, 1'b1));
    directed.push_back(tick_of(4096, 8190, 3, 7000, 4301, 4298, 1'b1));
    directed.push_back(tick_of(2000, 3000, 4000, 5000, 6000, 7000, 1'b0));
    // highest just above release, no cell past the band: counter steps down
    directed.push_back(tick_of(4199, 4201, 4200, 4199, 4199, 4199, 1'b1));
    directed.push_back(tick_of(0, 8191, 0, 8191, 0, 8191, 1'b1));
    directed.push_back(tick_of(8191, 0, 8191, 0, 8191, 0, 1'b1));
    // lowest at zero: every cell above 2 bleeds
    directed.push_back(tick_of(0, 4210, 4300, 8191, 2, 3, 1'b1));
    foreach (directed[i])
      send_tick(directed[i]);
    drain_pipe();

    // Random phases, each under its own register setting.
    for (p = 0; p < NUM_PHASES; p++) begin
      write_cfg(CFG_CELL_COUNT, phase_count[p]);
      write_cfg(CFG_RELEASE_MV, phase_release[p]);
      if (p == 3) begin
        // writes past the register list; nothing may change
        write_cfg(CFG_SPARE_A, CFG_DATA_W'($urandom_range(8191)));
        write_cfg(CFG_SPARE_B, CFG_DATA_W'($urandom_range(8191)));
      end
      steady = (p == 4);
      tight  = 1'b0;
      center = 0;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k % RUN_ITEMS == 0) begin
          tight  = ($urandom_range(99) < 40);
          center = run_center(tight);
        end
        // hold the sender mid-phase until everything is back
        if (k == PHASE_ITEMS / 2 && p == 0)
          drain_pipe();
        t = random_tick(tight, center);
        send_tick(t);
      end
      steady = 1'b0;
      drain_pipe();
    end

    $display("Run covered %0d ticks over %0d register settings, %0d results checked.",
             sb.items_seen, NUM_PHASES + 1, sb.results_checked);
    $display("Ticks with bleeding: %0d, ticks with finish flag set: %0d.",
             sb.bleed_ticks, sb.finished_ticks);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== passive_cell_balancer_top.f =====
hw/rtl/pcb_pkg.sv
hw/rtl/pcb_lane.sv
hw/rtl/pcb_merge.sv
hw/rtl/passive_cell_balancer_top.sv
test/passive_cell_balancer_top_tb.sv
